/* hdl/jse_pkg.sv */
// Shared types, constants and the escape table for the JSON string escaper.
package jse_pkg;

  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_LO_A   = 8'h61;
  localparam logic [7:0]  CH_UP_A   = 8'h41;
  localparam logic [20:0] CP_MIN    = 21'h000020;
  localparam logic [2:0]  REG_HEX_UPPER = 3'd0;

  typedef enum logic [1:0] {
    TK_CHAR = 2'd0,
    TK_ESC  = 2'd1,
    TK_ERR  = 2'd2,
    TK_UNI  = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [2:0]  ndig;
    logic [20:0] data;
  } tok_t;

  function automatic logic [7:0] esc_letter(input logic [7:0] b);
    logic [7:0] e;
    e = 8'h00;
    unique case (b)
      8'h22:   e = 8'h22;
      8'h5C:   e = 8'h5C;
      8'h2F:   e = 8'h2F;
      8'h08:   e = 8'h62;
      8'h0C:   e = 8'h66;
      8'h0A:   e = 8'h6E;
      8'h0D:   e = 8'h72;
      8'h09:   e = 8'h74;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

/* hdl/jse_front.sv */
// Front end: UTF-8 sequence assembly and classification of each byte into a request token.
module jse_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] in_byte
  input  logic           in_tlast,
  input  logic           q_full,
  output logic           push,
  output jse_pkg::tok_t  push_tok
);

  logic [2:0]  seq_len_r, seq_len_nxt;
  logic [2:0]  seq_rcv_r, seq_rcv_nxt;
  logic [20:0] acc_r, acc_nxt;

  logic        fire;
  logic        finish;
  logic [20:0] cp;
  logic [2:0]  rcv_inc;
  logic [7:0]  esc;
  jse_pkg::tok_t single_tok, uni_tok;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;
  assign esc       = jse_pkg::esc_letter(in_tdata);
  assign rcv_inc   = seq_rcv_r + 3'd1;

  always_comb begin
    single_tok.ndig = 3'd0;
    if (esc != 8'h00) begin
      single_tok.kind = jse_pkg::TK_ESC;
      single_tok.data = {13'd0, esc};
    end else if (in_tdata < 8'h20) begin
      single_tok.kind = jse_pkg::TK_ERR;
      single_tok.data = '0;
    end else begin
      single_tok.kind = jse_pkg::TK_CHAR;
      single_tok.data = {13'd0, in_tdata};
    end
  end

  always_comb begin
    uni_tok.data = cp;
    if (cp[20]) begin
      uni_tok.ndig = 3'd6;
    end else if (cp[19:16] != 4'd0) begin
      uni_tok.ndig = 3'd5;
    end else begin
      uni_tok.ndig = 3'd4;
    end
    if (cp < jse_pkg::CP_MIN || (cp[20] && cp[19:16] != 4'd0)) begin
      uni_tok.kind = jse_pkg::TK_ERR;
    end else begin
      uni_tok.kind = jse_pkg::TK_UNI;
    end
  end

  always_comb begin
    seq_len_nxt = seq_len_r;
    seq_rcv_nxt = seq_rcv_r;
    acc_nxt     = acc_r;
    finish      = 1'b0;
    cp          = '0;
    push        = 1'b0;
    push_tok    = single_tok;
    if (seq_len_r == 3'd0) begin
      priority if (in_tdata[7:5] == 3'b110) begin
        seq_len_nxt = 3'd2;
        cp          = {16'd0, in_tdata[4:0]};
        finish      = in_tlast;
      end else if (in_tdata[7:4] == 4'b1110) begin
        seq_len_nxt = 3'd3;
        cp          = {17'd0, in_tdata[3:0]};
        finish      = in_tlast;
      end else if (in_tdata[7:3] == 5'b11110) begin
        seq_len_nxt = 3'd4;
        cp          = {18'd0, in_tdata[2:0]};
        finish      = in_tlast;
      end else begin
        seq_len_nxt = 3'd0;
        push        = fire;
      end
      seq_rcv_nxt = (seq_len_nxt != 3'd0) ? 3'd1 : 3'd0;
      acc_nxt     = cp;
    end else begin
      cp          = {acc_r[14:0], in_tdata[5:0]};
      acc_nxt     = cp;
      seq_rcv_nxt = rcv_inc;
      finish      = !(rcv_inc < seq_len_r) || in_tlast;
    end
    if (finish) begin
      seq_len_nxt = 3'd0;
      seq_rcv_nxt = 3'd0;
      acc_nxt     = '0;
      push        = fire;
      push_tok    = uni_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= 3'd0;
      seq_rcv_r <= 3'd0;
      acc_r     <= '0;
    end else if (fire) begin
      seq_len_r <= seq_len_nxt;
      seq_rcv_r <= seq_rcv_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

/* hdl/jse_fifo.sv */
// Short token queue between the front end and the character expander.
module jse_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jse_pkg::tok_t  push_tok,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output jse_pkg::tok_t  head_tok
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jse_pkg::tok_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_tok = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

/* hdl/jse_back.sv */
// Back end: expands the head token into the output register, a character per cycle unless stalled.
module jse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hex_upper,
  input  logic           q_empty,
  input  jse_pkg::tok_t  head_tok,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,  // [7:0] out_char
  output logic           out_tlast,
  output logic           out_tuser   // [0] error_flag
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       err_r, err_nxt;

  logic       load;
  logic [2:0] last_idx;
  logic [2:0] dsel;
  logic [3:0] nib;
  logic [7:0] hex_ch;
  logic [7:0] ch;
  logic       is_err;

  assign load = !q_empty && (!valid_r || out_tready);
  assign dsel = head_tok.ndig + 3'd1 - idx_r;

  always_comb begin
    unique case (dsel)
      3'd0:    nib = head_tok.data[3:0];
      3'd1:    nib = head_tok.data[7:4];
      3'd2:    nib = head_tok.data[11:8];
      3'd3:    nib = head_tok.data[15:12];
      3'd4:    nib = head_tok.data[19:16];
      3'd5:    nib = {3'd0, head_tok.data[20]};
      default: nib = 4'd0;
    endcase
    if (nib < 4'd10) begin
      hex_ch = jse_pkg::CH_ZERO + {4'd0, nib};
    end else begin
      hex_ch = (hex_upper ? jse_pkg::CH_UP_A : jse_pkg::CH_LO_A) + {4'd0, nib} - 8'd10;
    end
  end

  always_comb begin
    is_err = 1'b0;
    unique case (head_tok.kind)
      jse_pkg::TK_CHAR: begin
        last_idx = 3'd0;
        ch       = head_tok.data[7:0];
      end
      jse_pkg::TK_ERR: begin
        last_idx = 3'd0;
        ch       = 8'h00;
        is_err   = 1'b1;
      end
      jse_pkg::TK_ESC: begin
        last_idx = 3'd1;
        ch       = (idx_r == 3'd0) ? jse_pkg::CH_BSLASH : head_tok.data[7:0];
      end
      jse_pkg::TK_UNI: begin
        last_idx = head_tok.ndig + 3'd1;
        if (idx_r == 3'd0) begin
          ch = jse_pkg::CH_BSLASH;
        end else if (idx_r == 3'd1) begin
          ch = jse_pkg::CH_U;
        end else begin
          ch = hex_ch;
        end
      end
      default: begin
        last_idx = 3'd0;
        ch       = 8'h00;
      end
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    valid_nxt = valid_r && !out_tready;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      char_nxt  = ch;
      err_nxt   = is_err;
      last_nxt  = (idx_r == last_idx);
      if (idx_r == last_idx) begin
        pop     = 1'b1;
        idx_nxt = 3'd0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

endmodule

/* hdl/json_string_escaper.sv */
// JSON string escaper top level: front end, token queue, character expander and register port.
//
// Input stream: one UTF-8 byte per request on in_tdata, in_tlast on the final byte
// of a string. Output stream: one escaped ASCII character per request on out_tdata,
// out_tlast on the last character produced by an input byte, out_tuser set on an
// error request (invalid character, out_tdata zero, always the only one for its byte).
// Register hex_upper at byte address 0 selects uppercase hex digits in \u escapes.
// An accepted byte is classified in the cycle it is taken and queued as a token;
// its first character goes from the queue head into the output register. A lead
// or middle continuation byte that does not end a sequence produces nothing.
// Output rate is one character per cycle while out_tready is high, set by the single
// expander; plain bytes go through at one per cycle, a byte that expands to n characters
// (2 for short escapes, 6 to 8 for \u escapes) occupies the expander until all n are
// out, while the queue of QDEPTH tokens absorbs following bytes.
// Reset clears the sequence state, the queue, the output valid flag and hex_upper.
// When out_tready is low the output register holds; the queue fills and then
// in_tready drops until characters drain.
module json_string_escaper #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_char
  output logic        out_tlast,
  output logic        out_tuser,   // [0] error_flag
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] ADDR_HEX_UPPER = 3'(4 * jse_pkg::REG_HEX_UPPER);

  logic          hex_upper_r;
  logic          q_full, q_empty, push, pop;
  jse_pkg::tok_t push_tok, head_tok;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_HEX_UPPER) ? {31'd0, hex_upper_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_upper_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr == ADDR_HEX_UPPER) begin
      hex_upper_r <= cfg_pwdata[0];
    end
  end

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_tok  (push_tok)
  );

  jse_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_tok (head_tok)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .hex_upper  (hex_upper_r),
    .q_empty    (q_empty),
    .head_tok   (head_tok),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* hdl/jse_checker.sv */
// Port-level assertions for the JSON string escaper, bound to the top level.
module jse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser,
  input logic       cfg_pready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output request changed while stalled");

  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00 && out_tlast)
    else $error("error request carries a character or is not last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_pready)
    else $error("output valid after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

/* verif/tb_json_string_escaper.sv */
// Testbench for json_string_escaper: UTF-8 byte stream in, predicted JSON escaped characters out.
`timescale 1ns / 100ps

module tb_json_string_escaper;

  localparam int          LIMIT_CYCLES   = 200000;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          HOLD_OFF_LEN   = 200;
  localparam logic [2:0]  ADDR_HEX_UPPER = 3'(4 * jse_pkg::REG_HEX_UPPER);
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [7:0]  ESC_SRC [8]    = '{8'h22, 8'h5C, 8'h2F, 8'h08,
                                             8'h0C, 8'h0A, 8'h0D, 8'h09};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } esc_char_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } utf8_req_t;

  class escape_scoreboard;
    logic        hex_upper;
    logic [2:0]  seq_len;
    logic [2:0]  seq_rcv;
    logic [20:0] cp_acc;
    esc_char_t   expected_chars[$];
    int          fails;
    int          bytes_noted;
    int          chars_checked;
    int          err_checked;

    function new();
      hex_upper     = 1'b0;
      seq_len       = '0;
      seq_rcv       = '0;
      cp_acc        = '0;
      fails         = 0;
      bytes_noted   = 0;
      chars_checked = 0;
      err_checked   = 0;
    endfunction

    function void set_hex_upper(logic v);
      hex_upper = v;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void add(logic [7:0] ch, logic last, logic err);
      expected_chars.push_back('{ch, last, err});
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return jse_pkg::CH_ZERO + 8'(nib);
      return (hex_upper ? jse_pkg::CH_UP_A : jse_pkg::CH_LO_A) + 8'(nib) - 8'd10;
    endfunction

    function void expand_single(logic [7:0] b);
      logic [7:0] esc;
      case (b)
        8'h22:   esc = "\"";
        8'h5C:   esc = "\\";
        8'h2F:   esc = "/";
        8'h08:   esc = "b";
        8'h0C:   esc = "f";
        8'h0A:   esc = "n";
        8'h0D:   esc = "r";
        8'h09:   esc = "t";
        default: esc = 8'h00;
      endcase
      if (esc != 8'h00) begin
        add(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
        add(esc, 1'b1, 1'b0);
      end else if (b < 8'h20) begin
        add(8'h00, 1'b1, 1'b1);
      end else begin
        add(b, 1'b1, 1'b0);
      end
    endfunction

    function void expand_code_point(logic [20:0] cp);
      logic [23:0] wide;
      int          digits;
      if (cp < jse_pkg::CP_MIN || cp > CP_MAX) begin
        add(8'h00, 1'b1, 1'b1);
        return;
      end
      wide   = {3'b000, cp};
      digits = wide[23:20] != 0 ? 6 : (wide[19:16] != 0 ? 5 : 4);
      add(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
      add(jse_pkg::CH_U, 1'b0, 1'b0);
      for (int d = digits - 1; d >= 0; d--)
        add(hex_char(wide[4*d +: 4]), d == 0, 1'b0);
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      logic [20:0] cp;
      bytes_noted++;
      if (seq_len == 0) begin
        if (b[7:5] == 3'b110) begin
          seq_len = 3'd2;
          cp_acc  = 21'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          seq_len = 3'd3;
          cp_acc  = 21'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          seq_len = 3'd4;
          cp_acc  = 21'(b[2:0]);
        end else begin
          expand_single(b);
          return;
        end
        seq_rcv = 3'd1;
        if (!eos) return;
      end else begin
        cp_acc  = {cp_acc[14:0], b[5:0]};
        seq_rcv = seq_rcv + 3'd1;
        if (seq_rcv < seq_len && !eos) return;
      end
      cp      = cp_acc;
      seq_len = '0;
      seq_rcv = '0;
      cp_acc  = '0;
      expand_code_point(cp);
    endfunction

    function void check_char(logic [7:0] ch, logic last, logic err);
      esc_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char, expected none, got ch=%h last=%b err=%b",
                 $time, ch, last, err);
        fails++;
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (err) err_checked++;
      if (want.ch !== ch || want.last !== last || want.err !== err) begin
        $display("%0t: char mismatch, expected ch=%h last=%b err=%b, got ch=%h last=%b err=%b",
                 $time, want.ch, want.last, want.err, ch, last, err);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  escape_scoreboard sb;
  utf8_req_t        tx_q[$];
  int               cycles;
  int               rx_hold;
  bit               rx_idle_en;

  json_string_escaper u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_char(out_tdata, out_tlast, out_tuser);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = 0;
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 10);
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    tx_q.push_back('{b, 1'b0});
  endfunction

  function automatic logic [7:0] lead_byte(int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  function automatic void queue_string(int nchars);
    int        r;
    int        len;
    utf8_req_t tail;
    for (int i = 0; i < nchars; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        push_byte(8'($urandom_range(8'h20, 8'h7E)));
      end else if (r < 40) begin
        push_byte(ESC_SRC[$urandom_range(0, 7)]);
      end else if (r < 45) begin
        push_byte(8'($urandom_range(0, 8'h1F)));
      end else if (r < 80) begin
        len = $urandom_range(2, 4);
        push_byte(lead_byte(len));
        repeat (len - 1) push_byte(cont_byte());
      end else if (r < 90) begin
        // broken sequence: lead followed by arbitrary bytes
        len = $urandom_range(2, 4);
        push_byte(lead_byte(len));
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end else begin
        push_byte(8'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      // cut the string short inside a sequence
      len = $urandom_range(2, 4);
      push_byte(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) push_byte(cont_byte());
    end
    tail     = tx_q.pop_back();
    tail.eos = 1'b1;
    tx_q.push_back(tail);
  endfunction

  function automatic void queue_random_text(int target);
    while (tx_q.size() < target) queue_string($urandom_range(1, 8));
  endfunction

  task automatic send_byte(input utf8_req_t req, input bit idle);
    int gap;
    gap = 0;
    if (idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = req.b;
    in_tlast  = req.eos;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(req.b, req.eos);
  endtask

  task automatic send_all(input bit idle);
    while (tx_q.size() > 0) send_byte(tx_q.pop_front(), idle);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_HEX_UPPER) sb.set_hex_upper(data[0]);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  initial begin
    sb          = new();
    cycles      = 0;
    rx_hold     = 0;
    rx_idle_en  = 1'b1;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cfg_write(ADDR_HEX_UPPER, 32'd0);
    foreach (ESC_SRC[i]) push_byte(ESC_SRC[i]);
    push_byte(8'h41);
    push_byte(8'h00);
    push_byte(8'h80);
    push_byte(8'hFF);
    push_byte(8'hC3); push_byte(8'hA9);
    push_byte(8'hF0); push_byte(8'h9F); push_byte(8'h98); push_byte(8'h80);
    push_byte(8'hC0); push_byte(8'h80);
    tx_q.push_back('{8'hE2, 1'b1});
    push_byte(8'hF4); push_byte(8'h90); push_byte(8'h80);
    tx_q.push_back('{8'h80, 1'b1});
    send_all(1'b1);
    wait_drained();

    // hold the output long enough to back up the input
    cfg_write(ADDR_HEX_UPPER, 32'd1);
    rx_hold = HOLD_OFF_LEN;
    queue_random_text(50);
    send_all(1'b1);
    wait_drained();

    cfg_write(ADDR_HEX_UPPER, 32'd0);
    queue_random_text(50);
    send_all(1'b1);
    wait_drained();

    cfg_write(ADDR_HEX_UPPER, 32'd1);
    rx_idle_en = 1'b0;
    queue_random_text(45);
    send_all(1'b0);
    wait_drained();

    $display("covered %0d input bytes and %0d output characters, %0d of them error results",
             sb.bytes_noted, sb.chars_checked, sb.err_checked);
    $display("exercised both hex cases, stalls on both sides and a long output hold-off");
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
